// ----- hw/rtl/ptcc_pkg.sv -----
// Shared types, codes and constants of the text cell compositor.
package ptcc_pkg;

   // Default store geometry
   localparam int DEF_MAX_COLS = 256;
   localparam int DEF_MAX_ROWS = 64;

   // Configuration register indexes and reset values
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;
   localparam logic [8:0] SCREEN_WIDTH_RESET  = 9'd80;
   localparam logic [6:0] SCREEN_HEIGHT_RESET = 7'd25;

   // Function codes of an input item
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_DRAW  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_HIDDEN  = 2'd2;
   localparam logic [1:0] STATUS_CLEARED = 2'd3;

   // Work kinds handed from the front to the back
   localparam logic [1:0] KIND_CLEAR   = 2'd0;
   localparam logic [1:0] KIND_DRAW    = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;
   localparam logic [1:0] KIND_OUTSIDE = 2'd3;

   localparam logic [7:0]  BLANK_CHAR  = 8'h20;
   localparam logic [31:0] EMPTY_ORDER = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0]  ch;
      logic [15:0] attr;
      logic [31:0] ord;
   } cell_type;

   typedef struct packed {
      logic [1:0] kind;
      cell_type   content;
   } work_type;

   localparam int WORK_BITS = $bits(work_type);

   localparam cell_type BLANK_CELL = cell_type'({BLANK_CHAR, 16'h0000, EMPTY_ORDER});

endpackage

// ----- hw/rtl/ptcc_front.sv -----
// Front end: accepts items, bounds-checks the cell and forms the store address.
module ptcc_front import ptcc_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS,
   localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic signed [15:0] req_start_col,
   input  logic signed [15:0] req_row,
   input  logic [15:0]        req_char_offset,
   input  logic [7:0]         req_char_code,
   input  logic [15:0]        req_color,
   input  logic signed [31:0] req_order,
   input  logic [8:0]         screen_width,
   input  logic [6:0]         screen_height,
   input  logic               q_full,
   input  logic               init_busy,
   output logic               q_push,
   output logic [AW-1:0]      q_push_addr,
   output work_type           q_push_work
);

   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [17:0] col_sum;
   logic [15:0] row_bits;
   logic [16:0] w_lim;
   logic [15:0] h_lim;
   logic        cell_in;

   // Column at full precision: signed start plus unsigned offset
   assign col_sum  = {{2{req_start_col[15]}}, req_start_col} + {2'b00, req_char_offset};
   assign row_bits = req_row;

   // Clamp the configured screen to the store geometry
   assign w_lim = (17'(screen_width) > 17'(MAX_COLS)) ? 17'(MAX_COLS) : 17'(screen_width);
   assign h_lim = (16'(screen_height) > 16'(MAX_ROWS)) ? 16'(MAX_ROWS) : 16'(screen_height);

   assign cell_in = !col_sum[17] && (col_sum[16:0] < w_lim) &&
                    !row_bits[15] && (row_bits < h_lim);

   assign q_push_addr = AW'(AW'(row_bits[RW-1:0]) * AW'(MAX_COLS)) + AW'(col_sum[CW-1:0]);

   always_comb begin
      q_push_work.content.ch   = req_char_code;
      q_push_work.content.attr = req_color;
      q_push_work.content.ord  = req_order;
      case (req_func)
         FUNC_CLEAR: q_push_work.kind = KIND_CLEAR;
         FUNC_DRAW:  q_push_work.kind = cell_in ? KIND_DRAW : KIND_OUTSIDE;
         FUNC_READ:  q_push_work.kind = cell_in ? KIND_READ : KIND_OUTSIDE;
         default:    q_push_work.kind = KIND_OUTSIDE;
      endcase
   end

   assign req_stall = q_full || init_busy;
   assign q_push    = req_valid && !req_stall;

endmodule

// ----- hw/rtl/ptcc_queue.sv -----
// Two-entry queue between the front end and the cell engine.
module ptcc_queue #(
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output logic [DW-1:0] head
);

   logic [DW-1:0] slots_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/ptcc_back.sv -----
// Cell engine: cell store, read-compare-write, clear sweep and result register.
module ptcc_back import ptcc_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS,
   localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  logic [AW-1:0]      q_addr,
   input  work_type           q_work,
   output logic               q_pop,
   output logic               init_busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_cell_char,
   output logic [15:0]        rsp_cell_attr,
   output logic signed [31:0] rsp_cell_order
);

   localparam logic [1:0] ST_INIT  = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;
   localparam logic [1:0] ST_SWEEP = 2'd3;
   localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);

   cell_type cell_mem [CELL_COUNT];
   cell_type rd_data_ff;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   work_type      cur_ff, cur_in;
   logic [AW-1:0] cur_addr_ff, cur_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff;
   cell_type      rsp_cell_ff;

   logic          out_free;
   logic          rd_en;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   cell_type      wr_data;
   logic          load;
   logic [1:0]    load_status;
   cell_type      load_cell;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign init_busy = (state_ff == ST_INIT);

   always_comb begin
      state_in    = state_ff;
      sweep_in    = sweep_ff;
      cur_in      = cur_ff;
      cur_addr_in = cur_addr_ff;
      q_pop       = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = sweep_ff;
      wr_data     = BLANK_CELL;
      load        = 1'b0;
      load_status = STATUS_OK;
      load_cell   = '0;
      case (state_ff)
         ST_INIT: begin
            wr_en = 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_work.kind)
                  KIND_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
                  KIND_DRAW, KIND_READ: begin
                     rd_en       = 1'b1;
                     cur_in      = q_work;
                     cur_addr_in = q_addr;
                     state_in    = ST_LOOK;
                  end
                  default: begin
                     load        = 1'b1;
                     load_status = STATUS_OUTSIDE;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               if (cur_ff.kind == KIND_DRAW) begin
                  if ($signed(rd_data_ff.ord) > $signed(cur_ff.content.ord)) begin
                     load_status = STATUS_HIDDEN;
                     load_cell   = rd_data_ff;
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = cur_addr_ff;
                     wr_data   = cur_ff.content;
                     load_cell = cur_ff.content;
                  end
               end else begin
                  load_cell = rd_data_ff;
               end
            end
         end
         ST_SWEEP: begin
            wr_en = 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               if (out_free) begin
                  load        = 1'b1;
                  load_status = STATUS_CLEARED;
                  load_cell   = BLANK_CELL;
                  sweep_in    = '0;
                  state_in    = ST_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cell_mem[q_addr];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      cur_addr_ff <= cur_addr_in;
      if (load) begin
         rsp_status_ff <= load_status;
         rsp_cell_ff   <= load_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_cell_char  = rsp_cell_ff.ch;
   assign rsp_cell_attr  = rsp_cell_ff.attr;
   assign rsp_cell_order = $signed(rsp_cell_ff.ord);

endmodule

// ----- hw/rtl/priority_text_cell_compositor_unit.sv -----
// Top level of the priority text cell compositor: screen registers, front, queue, engine.
//
//   channel   direction  handshake            payload
//   req_*     in         req_valid/req_stall  func, start_col, row, char_offset,
//                                              char_code, color, order
//   rsp_*     out        rsp_valid/rsp_stall  status, cell_char, cell_attr, cell_order
//   csr_*     in         csr_wen              csr_index, csr_wdata (screen width/height)
//
// In the cell engine a draw or read item first takes the registered store read, then
// the order compare, the write and the result load.
// An out-of-screen item or an unused function code loads its result straight from idle.
// A clear item sweeps the store one cell a cycle; the last cell waits on rsp_stall.
// After reset the engine runs the same sweep and holds req_stall high until it ends;
// configuration writes are taken throughout.
// The two-entry queue lets the front keep accepting while the engine waits on rsp_stall.
module priority_text_cell_compositor_unit import ptcc_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic signed [15:0] req_start_col,
   input  logic signed [15:0] req_row,
   input  logic [15:0]        req_char_offset,
   input  logic [7:0]         req_char_code,
   input  logic [15:0]        req_color,
   input  logic signed [31:0] req_order,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_cell_char,
   output logic [15:0]        rsp_cell_attr,
   output logic signed [31:0] rsp_cell_order,
   // configuration port
   input  logic               csr_wen,
   input  logic               csr_index,
   input  logic [8:0]         csr_wdata
);

   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int QW = AW + WORK_BITS;

   logic [8:0]    screen_width_ff, screen_width_in;
   logic [6:0]    screen_height_ff, screen_height_in;

   logic          q_push;
   logic [AW-1:0] q_push_addr;
   work_type      q_push_work;
   logic          q_full;
   logic          q_pop;
   logic          q_valid;
   logic [QW-1:0] q_head;
   logic          init_busy;

   // Screen registers: a write lands on the edge where csr_wen is high
   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata[6:0];
            default: begin
               screen_width_in = screen_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   // Classify each transfer and compute its cell address
   ptcc_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_start_col   (req_start_col),
      .req_row         (req_row),
      .req_char_offset (req_char_offset),
      .req_char_code   (req_char_code),
      .req_color       (req_color),
      .req_order       (req_order),
      .screen_width    (screen_width_ff),
      .screen_height   (screen_height_ff),
      .q_full          (q_full),
      .init_busy       (init_busy),
      .q_push          (q_push),
      .q_push_addr     (q_push_addr),
      .q_push_work     (q_push_work)
   );

   // Decouple the front from the engine
   ptcc_queue #(
      .DW (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({q_push_addr, q_push_work}),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   // Carry out the work: store access, order test, clear sweep, result register
   ptcc_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_addr         (q_head[QW-1:WORK_BITS]),
      .q_work         (work_type'(q_head[WORK_BITS-1:0])),
      .q_pop          (q_pop),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_cell_order (rsp_cell_order)
   );

   // No transfer is taken while the power-up sweep runs
   assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !q_push)
      else $error("item accepted during the power-up sweep");

   // The queue never takes an entry while full
   assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("queue overflow");

   // A cleared result always shows the blank cell
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_CLEARED) |->
         (rsp_cell_char == BLANK_CHAR && rsp_cell_attr == 16'h0000 &&
          rsp_cell_order == $signed(EMPTY_ORDER)))
      else $error("clear result does not show the blank cell");

   // An outside result always carries zero cell fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OUTSIDE) |->
         (rsp_cell_char == 8'h00 && rsp_cell_attr == 16'h0000 && rsp_cell_order == 32'sd0))
      else $error("outside result carries cell data");

endmodule

// ----- sim/priority_text_cell_compositor_unit_test.sv -----
// Self-checking testbench of the priority text cell compositor unit.
`timescale 1ns / 1ps

module priority_text_cell_compositor_unit_test;
   import ptcc_pkg::*;

   localparam int          CELL_COUNT  = DEF_MAX_COLS * DEF_MAX_ROWS;
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;
   localparam int unsigned QUIET_LIMIT = 100000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int          PHASE_COUNT = 7;

   // Screen settings per random phase; the last one is drawn at run time.
   // Height data carries bits above the register width on purpose.
   localparam logic [8:0] PHASE_WIDTH  [PHASE_COUNT] = '{9'd256, 9'd1, 9'd511, 9'd0,
                                                         9'd257, 9'd13, 9'd80};
   localparam logic [8:0] PHASE_HEIGHT [PHASE_COUNT] = '{9'h040, 9'd1, 9'h1FF, 9'h180,
                                                         9'd65, 9'd7, 9'd25};
   localparam int PHASE_ITEMS [PHASE_COUNT] = '{200, 80, 150, 30, 120, 250, 150};

   typedef struct {
      logic [1:0]         func;
      logic signed [15:0] start_col;
      logic signed [15:0] row;
      logic [15:0]        char_offset;
      logic [7:0]         char_code;
      logic [15:0]        color;
      logic signed [31:0] order;
   } char_cmd_t;

   typedef struct {
      logic [1:0]         status;
      logic [7:0]         ch;
      logic [15:0]        attr;
      logic signed [31:0] ord;
   } cell_result_t;

   // Mirror of the frame store and the screen registers; holds the cell
   // contents each accepted command should report, oldest first.
   class cell_frame_scoreboard;
      logic [7:0]         char_mem  [CELL_COUNT];
      logic [15:0]        attr_mem  [CELL_COUNT];
      logic signed [31:0] order_mem [CELL_COUNT];
      logic [8:0]         width_reg;
      logic [6:0]         height_reg;
      cell_result_t       expected_q [$];
      int unsigned        mismatches;

      function new();
         wipe();
         width_reg  = SCREEN_WIDTH_RESET;
         height_reg = SCREEN_HEIGHT_RESET;
         mismatches = 0;
      endfunction

      function void wipe();
         for (int i = 0; i < CELL_COUNT; i++) begin
            char_mem[i]  = BLANK_CHAR;
            attr_mem[i]  = 16'h0000;
            order_mem[i] = EMPTY_ORDER;
         end
      endfunction

      function void set_screen(logic index, logic [8:0] value);
         if (index == CSR_SCREEN_WIDTH)
            width_reg = value;
         else
            height_reg = value[6:0];
      endfunction

      function void note_request(char_cmd_t c);
         cell_result_t r;
         int col, rw, w, h, idx;
         w = (width_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(width_reg);
         h = (height_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(height_reg);
         // column is taken at full precision, so a large offset never wraps back in
         col = c.start_col;
         col = col + int'(c.char_offset);
         rw  = c.row;
         r = '{STATUS_OUTSIDE, 8'h00, 16'h0000, 32'sd0};
         if (c.func == FUNC_CLEAR) begin
            wipe();
            r = '{STATUS_CLEARED, BLANK_CHAR, 16'h0000, EMPTY_ORDER};
         end else if (c.func != FUNC_UNUSED && col >= 0 && col < w && rw >= 0 && rw < h) begin
            idx = rw * DEF_MAX_COLS + col;
            if (c.func == FUNC_DRAW && $signed(order_mem[idx]) > $signed(c.order)) begin
               r.status = STATUS_HIDDEN;
            end else begin
               r.status = STATUS_OK;
               if (c.func == FUNC_DRAW) begin
                  char_mem[idx]  = c.char_code;
                  attr_mem[idx]  = c.color;
                  order_mem[idx] = c.order;
               end
            end
            r.ch   = char_mem[idx];
            r.attr = attr_mem[idx];
            r.ord  = order_mem[idx];
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(cell_result_t got);
         cell_result_t want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with nothing outstanding: status %0d char %02h",
                        $time, got.status, got.ch);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status || got.ch !== want.ch ||
             got.attr !== want.attr || got.ord !== want.ord) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: mismatch (expected/actual) status %0d/%0d char %02h/%02h",
                         " attr %04h/%04h order %0d/%0d"}, $time, want.status, got.status,
                        want.ch, got.ch, want.attr, got.attr, want.ord, got.ord);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_func;
   logic signed [15:0] req_start_col;
   logic signed [15:0] req_row;
   logic [15:0]        req_char_offset;
   logic [7:0]         req_char_code;
   logic [15:0]        req_color;
   logic signed [31:0] req_order;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_cell_char;
   logic [15:0]        rsp_cell_attr;
   logic signed [31:0] rsp_cell_order;
   logic               csr_wen;
   logic               csr_index;
   logic [8:0]         csr_wdata;

   cell_frame_scoreboard sb = new();
   int unsigned items_sent = 0;
   int unsigned quiet_cycles = 0;

   priority_text_cell_compositor_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_start_col   (req_start_col),
      .req_row         (req_row),
      .req_char_offset (req_char_offset),
      .req_char_code   (req_char_code),
      .req_color       (req_color),
      .req_order       (req_order),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_cell_char   (rsp_cell_char),
      .rsp_cell_attr   (rsp_cell_attr),
      .rsp_cell_order  (rsp_cell_order),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic char_cmd_t mk(logic [1:0] func, logic signed [15:0] start_col,
                                    logic signed [15:0] row, logic [15:0] char_offset,
                                    logic [7:0] char_code, logic [15:0] color,
                                    logic signed [31:0] order);
      char_cmd_t c;
      c = '{func, start_col, row, char_offset, char_code, color, order};
      return c;
   endfunction

   // Offer one command after a random gap and hold it until the transfer.
   // Valid stays high on return so a zero gap keeps the stream back to back.
   task automatic send_item(input char_cmd_t c);
      int unsigned gap;
      // every fourth window of 50 items runs without gaps
      gap = (((items_sent / 50) % 4) == 3) ? 0 : $urandom_range(0, 15);
      items_sent++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= c.func;
      req_start_col   <= c.start_col;
      req_row         <= c.row;
      req_char_offset <= c.char_offset;
      req_char_code   <= c.char_code;
      req_color       <= c.color;
      req_order       <= c.order;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   // Drop valid and wait until every outstanding result has come back.
   // Step one edge first so the transfer just made is already noted.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   // Note each input transfer in the mirror at the edge that takes it.
   always @(posedge clock) begin
      if (req_valid && !req_stall)
         sb.note_request('{req_func, req_start_col, req_row, req_char_offset,
                           req_char_code, req_color, req_order});
   end

   // Check each result transfer against the oldest expectation.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         sb.check_result('{rsp_status, rsp_cell_char, rsp_cell_attr, rsp_cell_order});
   end

   // Watchdog: count edges without any transfer on either channel. The reset
   // sweep and a clear each take one full pass over the store, well below the limit.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[priority_text_cell_compositor_unit] ERROR");
            $finish;
         end
      end
   end

   // Result side: after each transfer hold stall for a random count. Every fourth
   // window of 64 results runs without stalls, and now and then hold off for a long
   // stretch so the queue fills and the input side backs up.
   initial begin
      int unsigned seen;
      int unsigned hold;
      seen = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (seen % 400 == 150)
               hold = 300;
            else if (((seen / 64) % 4) == 3)
               hold = 0;
            else
               hold = $urandom_range(0, 15);
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin
      char_cmd_t  cmd;
      logic [8:0] w_data, h_data;
      int         cur_w, cur_h, col, rw, pick, offset;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_func        <= FUNC_READ;
      req_start_col   <= '0;
      req_row         <= '0;
      req_char_offset <= '0;
      req_char_code   <= '0;
      req_color       <= '0;
      req_order       <= '0;
      csr_wen         <= 1'b0;
      csr_index       <= CSR_SCREEN_WIDTH;
      csr_wdata       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset screen of 80 x 25; the block holds stall
      // through its startup sweep, so the first transfer simply waits for it.
      send_item(mk(FUNC_READ, 0, 0, 0, 8'h00, 16'h0000, 32'sd0));       // blank cell
      send_item(mk(FUNC_DRAW, 0, 0, 0, 8'h41, 16'h1234, -32'sd1));      // tie with empty wins
      send_item(mk(FUNC_DRAW, 0, 0, 0, 8'h42, 16'h5678, -32'sd2));      // lower order hidden
      send_item(mk(FUNC_DRAW, -5, 0, 5, 8'hFF, 16'hFFFF, 32'sh7FFF_FFFF));
      send_item(mk(FUNC_DRAW, 0, 0, 0, 8'h00, 16'h0000, 32'sh7FFF_FFFF)); // equal max wins
      send_item(mk(FUNC_DRAW, 1, 0, 0, 8'h43, 16'h0001, 32'sh8000_0000)); // min under empty
      send_item(mk(FUNC_DRAW, -10, 24, 89, 8'h44, 16'h00F0, 32'sd7));    // far corner
      send_item(mk(FUNC_DRAW, 0, 24, 80, 8'h45, 16'h0002, 32'sd9));      // one column past
      send_item(mk(FUNC_DRAW, 0, 25, 0, 8'h46, 16'h0003, 32'sd9));       // one row past
      send_item(mk(FUNC_DRAW, 5, -1, 0, 8'h47, 16'h0004, 32'sd9));       // negative row
      send_item(mk(FUNC_DRAW, -1, 3, 0, 8'h48, 16'h0005, 32'sd9));       // negative column
      send_item(mk(FUNC_DRAW, 16'sh7FFF, 3, 16'hFFFF, 8'h49, 16'h0006, 32'sd9)); // no wrap
      send_item(mk(FUNC_DRAW, 16'sh8000, 3, 16'd32770, 8'h4A, 16'hA5A5, 32'sd5));
      send_item(mk(FUNC_READ, 16'sh8000, 3, 16'd32770, 8'h00, 16'h0000, 32'sd0));
      send_item(mk(FUNC_UNUSED, 2, 3, 0, 8'h4B, 16'h0007, 32'sd9));      // unused code
      send_item(mk(FUNC_READ, 0, 25, 0, 8'h00, 16'h0000, 32'sd0));       // read outside
      send_item(mk(FUNC_DRAW, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 8'hFF, 16'hFFFF, -32'sd1));
      send_item(mk(FUNC_CLEAR, 0, 0, 0, 8'h00, 16'h0000, 32'sd0));
      send_item(mk(FUNC_READ, -10, 24, 89, 8'h00, 16'h0000, 32'sd0));    // blank again
      send_item(mk(FUNC_DRAW, 79, 24, 0, 8'h7E, 16'h8001, 32'sh8000_0000));
      send_item(mk(FUNC_DRAW, 79, 24, 0, 8'h7F, 16'h8002, -32'sd1));
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         w_data = PHASE_WIDTH[p];
         h_data = PHASE_HEIGHT[p];
         if (p == PHASE_COUNT - 1) begin
            w_data = 9'($urandom_range(1, 300));
            h_data = 9'($urandom_range(1, 127));
         end

         // Write both screen registers while the block is idle.
         csr_wen   <= 1'b1;
         csr_index <= CSR_SCREEN_WIDTH;
         csr_wdata <= w_data;
         @(posedge clock);
         sb.set_screen(CSR_SCREEN_WIDTH, w_data);
         csr_index <= CSR_SCREEN_HEIGHT;
         csr_wdata <= h_data;
         @(posedge clock);
         sb.set_screen(CSR_SCREEN_HEIGHT, h_data);
         csr_wen <= 1'b0;

         cur_w = (w_data > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(w_data);
         cur_h = (h_data[6:0] > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(h_data[6:0]);

         for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
            cmd.char_code   = 8'($urandom);
            cmd.color       = 16'($urandom);
            cmd.start_col   = 16'($urandom);
            cmd.row         = 16'($urandom);
            cmd.char_offset = 16'($urandom);
            // favor orders that tie or sit next to each other and the empty order
            case ($urandom_range(0, 7))
               0:       cmd.order = -32'sd1;
               1:       cmd.order = 32'sh8000_0000;
               2:       cmd.order = 32'sh7FFF_FFFF;
               3, 4, 5: cmd.order = 32'(int'($urandom_range(0, 8)) - 4);
               default: cmd.order = 32'($urandom);
            endcase
            pick = int'($urandom_range(0, 99));
            if ($urandom_range(0, 249) == 0) begin
               cmd.func = FUNC_CLEAR;
            end else if (cur_w == 0 || cur_h == 0 || pick >= 90) begin
               // noise: any cell, any non-clear code
               cmd.func = 2'($urandom_range(1, 3));
            end else begin
               cmd.func = (pick < 55 || (pick >= 80 && pick % 2 == 0)) ? FUNC_DRAW : FUNC_READ;
               if (pick < 80) begin
                  // half the time crowd a small corner so cells get overdrawn
                  if ($urandom_range(0, 1) == 1) begin
                     col = int'($urandom_range(0, (cur_w < 8 ? cur_w : 8) - 1));
                     rw  = int'($urandom_range(0, (cur_h < 4 ? cur_h : 4) - 1));
                  end else begin
                     col = int'($urandom_range(0, cur_w - 1));
                     rw  = int'($urandom_range(0, cur_h - 1));
                  end
               end else begin
                  // straddle the screen edges
                  col = cur_w - 2 + int'($urandom_range(0, 3));
                  if ($urandom_range(0, 3) == 0)
                     rw = -1 - int'($urandom_range(0, 2));
                  else
                     rw = cur_h - 1 + int'($urandom_range(0, 1));
               end
               // split the column into a start and an offset, sometimes a large one
               if ($urandom_range(0, 3) == 0)
                  offset = int'($urandom_range(0, col + 32768));
               else
                  offset = int'($urandom_range(0, 40));
               cmd.start_col   = 16'(col - offset);
               cmd.row         = 16'(rw);
               cmd.char_offset = 16'(offset);
            end
            send_item(cmd);
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("[priority_text_cell_compositor_unit] OK");
      else
         $display("[priority_text_cell_compositor_unit] ERROR");
      $finish;
   end

endmodule
